/* sv/tset_pkg.sv */
package tset_pkg;

    localparam int Capacity    = 64;
    localparam int IdxBits     = $clog2(Capacity);
    localparam int CountBits   = $clog2(Capacity + 1);
    localparam int PayloadBits = 32;
    localparam int KeyBits     = 11;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_READ   = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_CLEARED   = 3'd2,
        ST_READ_OK   = 3'd3,
        ST_BAD_INDEX = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ_WAIT,
        S_SHIFT,
        S_PLACE
    } t_state;

    typedef struct packed {
        logic [4:0]             hour;
        logic [5:0]             minute;
        logic [8:0]             slot;
        logic [PayloadBits-1:0] payload;
    } t_entry;

    // hour*60 + minute as (hour<<6) - (hour<<2) + minute
    function automatic logic [KeyBits-1:0] key_of(input logic [4:0] hour,
                                                  input logic [5:0] minute);
        key_of = {hour, 6'b0} - {4'b0, hour, 2'b0} + {5'b0, minute};
    endfunction

endpackage

/* sv/time_sorted_entry_table.sv */
// channel   | direction | ports                                             | handshake
// ----------+-----------+---------------------------------------------------+-------------------
// command   | in        | i_action, i_entry_hour, i_entry_minute,           | i_start & !o_busy
//           |           | i_source_slot, i_payload_handle, i_read_index     |
// result    | out       | o_status, o_out_hour, o_out_minute, o_out_slot,   | o_done, one cycle
//           |           | o_out_payload, o_insert_position, o_entry_count   |
//
// entries live in one 64-deep synchronous memory with a registered read.
// clear, full drop and read beyond count answer one cycle after the beat;
// a read waits in S_READ_WAIT for the registered memory data, an insert into an empty table writes position 0 at once.
// an insert walks down from the top entry, one memory read/write per cycle:
// each later entry moves up one place in S_SHIFT; landing at position 0 ends in S_PLACE.
// reset empties the table, not the memory; results last one cycle, never stalled.
module time_sorted_entry_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [1:0]        i_action,
    input  logic [4:0]        i_entry_hour,
    input  logic [5:0]        i_entry_minute,
    input  logic signed [8:0] i_source_slot,
    input  logic [31:0]       i_payload_handle,
    input  logic [5:0]        i_read_index,
    output logic              o_done,
    output logic [2:0]        o_status,
    output logic [4:0]        o_out_hour,
    output logic [5:0]        o_out_minute,
    output logic signed [8:0] o_out_slot,
    output logic [31:0]       o_out_payload,
    output logic [5:0]        o_insert_position,
    output logic [6:0]        o_entry_count
);

    tset_pkg::t_state r_state, n_state;
    logic [tset_pkg::IdxBits-1:0]   r_idx, n_idx;
    logic [tset_pkg::CountBits-1:0] r_count, n_count;
    tset_pkg::t_entry               r_new, n_new;
    logic [tset_pkg::KeyBits-1:0]   r_new_key, n_new_key;

    logic             r_done, n_done;
    tset_pkg::t_status r_status, n_status;
    logic [4:0]       r_hour, n_hour;
    logic [5:0]       r_minute, n_minute;
    logic [8:0]       r_slot, n_slot;
    logic [31:0]      r_payload, n_payload;
    logic [5:0]       r_pos, n_pos;

    tset_pkg::t_entry r_mem [tset_pkg::Capacity];
    tset_pkg::t_entry r_rdata;
    logic                         mem_we;
    logic [tset_pkg::IdxBits-1:0] mem_waddr;
    tset_pkg::t_entry             mem_wdata;
    logic [tset_pkg::IdxBits-1:0] rd_addr;

    logic  accept;
    logic  full;
    logic  stored_later;
    tset_pkg::t_entry in_entry;

    assign accept   = i_start && (r_state == tset_pkg::S_IDLE);
    assign full     = (r_count == tset_pkg::CountBits'(tset_pkg::Capacity));
    assign in_entry = '{hour: i_entry_hour, minute: i_entry_minute, slot: i_source_slot,
                        payload: tset_pkg::PayloadBits'(i_payload_handle)};
    assign stored_later = tset_pkg::key_of(r_rdata.hour, r_rdata.minute) > r_new_key;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tset_pkg::S_IDLE: begin
                if (accept) begin
                    case (tset_pkg::t_action'(i_action))
                        tset_pkg::ACT_INSERT: begin
                            if (!full && r_count != '0) begin
                                n_state = tset_pkg::S_SHIFT;
                            end
                        end
                        tset_pkg::ACT_READ: begin
                            if (tset_pkg::CountBits'(i_read_index) < r_count) begin
                                n_state = tset_pkg::S_READ_WAIT;
                            end
                        end
                        default: n_state = tset_pkg::S_IDLE;
                    endcase
                end
            end
            tset_pkg::S_READ_WAIT: n_state = tset_pkg::S_IDLE;
            tset_pkg::S_SHIFT: begin
                if (!stored_later) begin
                    n_state = tset_pkg::S_IDLE;
                end else if (r_idx == '0) begin
                    n_state = tset_pkg::S_PLACE;
                end
            end
            tset_pkg::S_PLACE: n_state = tset_pkg::S_IDLE;
            default: n_state = tset_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_idx     = r_idx;
        n_count   = r_count;
        n_new     = r_new;
        n_new_key = r_new_key;
        n_done    = 1'b0;
        n_status  = r_status;
        n_hour    = '0;
        n_minute  = '0;
        n_slot    = '0;
        n_payload = '0;
        n_pos     = '0;
        mem_we    = 1'b0;
        mem_waddr = r_idx + 1'b1;
        mem_wdata = r_new;
        rd_addr   = r_idx;
        case (r_state)
            tset_pkg::S_IDLE: begin
                if (accept) begin
                    case (tset_pkg::t_action'(i_action))
                        tset_pkg::ACT_INSERT: begin
                            n_new     = in_entry;
                            n_new_key = tset_pkg::key_of(i_entry_hour, i_entry_minute);
                            if (full) begin
                                n_done   = 1'b1;
                                n_status = tset_pkg::ST_FULL;
                            end else if (r_count == '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = in_entry;
                                n_count   = r_count + 1'b1;
                                n_done    = 1'b1;
                                n_status  = tset_pkg::ST_INSERTED;
                            end else begin
                                // start at the top entry and walk down
                                n_idx   = tset_pkg::IdxBits'(r_count - 1'b1);
                                rd_addr = n_idx;
                            end
                        end
                        tset_pkg::ACT_CLEAR: begin
                            n_count  = '0;
                            n_done   = 1'b1;
                            n_status = tset_pkg::ST_CLEARED;
                        end
                        tset_pkg::ACT_READ: begin
                            rd_addr = tset_pkg::IdxBits'(i_read_index);
                            if (tset_pkg::CountBits'(i_read_index) >= r_count) begin
                                n_done   = 1'b1;
                                n_status = tset_pkg::ST_BAD_INDEX;
                            end
                        end
                        default: n_done = 1'b0;
                    endcase
                end
            end
            tset_pkg::S_READ_WAIT: begin
                n_done    = 1'b1;
                n_status  = tset_pkg::ST_READ_OK;
                n_hour    = r_rdata.hour;
                n_minute  = r_rdata.minute;
                n_slot    = r_rdata.slot;
                n_payload = 32'(r_rdata.payload);
            end
            tset_pkg::S_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx + 1'b1;
                if (stored_later) begin
                    // move the later entry up, fetch the one below
                    mem_wdata = r_rdata;
                    if (r_idx != '0) begin
                        n_idx   = r_idx - 1'b1;
                        rd_addr = n_idx;
                    end
                end else begin
                    mem_wdata = r_new;
                    n_count   = r_count + 1'b1;
                    n_done    = 1'b1;
                    n_status  = tset_pkg::ST_INSERTED;
                    n_pos     = 6'(r_idx + 1'b1);
                end
            end
            tset_pkg::S_PLACE: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_new;
                n_count   = r_count + 1'b1;
                n_done    = 1'b1;
                n_status  = tset_pkg::ST_INSERTED;
            end
            default: n_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tset_pkg::S_IDLE;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_status <= tset_pkg::ST_INSERTED;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_done   <= n_done;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_new     <= n_new;
        r_new_key <= n_new_key;
        r_hour    <= n_hour;
        r_minute  <= n_minute;
        r_slot    <= n_slot;
        r_payload <= n_payload;
        r_pos     <= n_pos;
    end

    assign o_busy            = (r_state != tset_pkg::S_IDLE);
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_out_hour        = r_hour;
    assign o_out_minute      = r_minute;
    assign o_out_slot        = r_slot;
    assign o_out_payload     = r_payload;
    assign o_insert_position = r_pos;
    assign o_entry_count     = 7'(r_count);

endmodule
